FILE: rtl/core/csm_pkg.sv
// Shared constants for the set-associative LRU cache tag model.
`timescale 1ns / 1ps
package csm_pkg;

   // Defaults for the top-level parameters. LINE_SIZE must be a power of two.
   localparam int DEF_LINE_SIZE = 64;
   localparam int DEF_WAYS      = 4;
   localparam int DEF_MAX_SETS  = 128;
   localparam int DEF_ADDR_BITS = 32;

   // Set-count register.
   localparam int            CSR_W          = 8;
   localparam logic [CSR_W-1:0] NUM_SETS_RESET = 8'd2;

   // Miss counter width.
   localparam int MISS_W = 32;

   // Quotient bits retired per cycle by the set-index remainder unit.
   localparam int REM_STEPS = 4;

endpackage

FILE: rtl/core/set_assoc_lru_cache_model.sv
// Flow: an accepted item runs through the iterative set-index remainder unit, then one read
//    and one write of the set row; the result shows one cycle, the receiver cannot stall.
// Items do not overlap: busy holds off a new item until the set row of the last one has
//    been written.
// Reset clears the miss counter and control state and sets num_sets to 2, then a clearing
//    pass zeroes one set row per cycle and holds busy until all MAX_SETS rows are clear.
`timescale 1ns / 1ps
module set_assoc_lru_cache_model
   import csm_pkg::*;
#(
   parameter int LINE_SIZE  = DEF_LINE_SIZE,
   parameter int WAYS       = DEF_WAYS,
   parameter int MAX_SETS   = DEF_MAX_SETS,
   parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ADDR_BITS-1:0] req_byte_address,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [MISS_W-1:0]    rsp_miss_total,
   input  logic                 csr_write_en,
   input  logic [CSR_W-1:0]     csr_num_sets
);

   localparam int OFFSET_BITS = $clog2(LINE_SIZE);
   localparam int LINE_BITS   = ADDR_BITS - OFFSET_BITS;
   localparam int SET_BITS    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int RANK_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIV    = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CSR_W-1:0]     num_sets_ff;
   logic [LINE_BITS-1:0] line_ff;
   logic [SET_BITS-1:0]  set_ff;
   logic [MISS_W-1:0]    miss_ff, miss_in;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;

   logic                 accept;
   logic                 clearing;
   logic [CSR_W-1:0]     eff_sets;
   logic                 rem_done;
   logic [CSR_W-1:0]     rem_val;
   logic [SET_BITS-1:0]  rem_set;
   logic                 rd_en;
   logic                 wr_en;
   logic                 hit;

   logic [WAYS-1:0][LINE_BITS-1:0] rd_tags, new_tags;
   logic [WAYS-1:0][RANK_BITS-1:0] rd_ranks, new_ranks;
   logic [WAYS-1:0]                rd_valid, new_valid;

   assign busy   = (state_ff != ST_IDLE) || clearing;
   assign accept = start && !busy;

   // A zero set count acts as one; anything above the table size is clamped.
   always_comb begin
      if (num_sets_ff == '0) begin
         eff_sets = CSR_W'(1);
      end else if (32'(num_sets_ff) > MAX_SETS) begin
         eff_sets = CSR_W'(MAX_SETS);
      end else begin
         eff_sets = num_sets_ff;
      end
   end

   csm_set_rem #(
      .LINE_BITS (LINE_BITS)
   ) u_set_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_byte_address[ADDR_BITS-1:OFFSET_BITS]),
      .divisor  (eff_sets),
      .done     (rem_done),
      .rem      (rem_val)
   );

   assign rem_set = SET_BITS'(rem_val);
   assign rd_en   = (state_ff == ST_DIV) && rem_done;
   assign wr_en   = (state_ff == ST_UPDATE);

   csm_way_store #(
      .SETS      (MAX_SETS),
      .WAYS      (WAYS),
      .LINE_BITS (LINE_BITS),
      .RANK_BITS (RANK_BITS)
   ) u_way_store (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .rd_en    (rd_en),
      .rd_set   (rem_set),
      .rd_tags  (rd_tags),
      .rd_ranks (rd_ranks),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_set   (set_ff),
      .wr_tags  (new_tags),
      .wr_ranks (new_ranks),
      .wr_valid (new_valid)
   );

   csm_lru_logic #(
      .WAYS      (WAYS),
      .LINE_BITS (LINE_BITS),
      .RANK_BITS (RANK_BITS)
   ) u_lru_logic (
      .line      (line_ff),
      .tags      (rd_tags),
      .ranks     (rd_ranks),
      .valid     (rd_valid),
      .hit       (hit),
      .new_tags  (new_tags),
      .new_ranks (new_ranks),
      .new_valid (new_valid)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Saturate the miss count.
   always_comb begin
      miss_in = miss_ff;
      if (wr_en && !hit && (miss_ff != '1)) begin
         miss_in = miss_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_sets_ff  <= NUM_SETS_RESET;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= wr_en;
         if (csr_write_en) begin
            num_sets_ff <= csr_num_sets;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_ff <= req_byte_address[ADDR_BITS-1:OFFSET_BITS];
      end
      if (rd_en) begin
         set_ff <= rem_set;
      end
      if (wr_en) begin
         rsp_hit_ff <= hit;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_miss_total = miss_ff;

endmodule

FILE: rtl/core/csm_set_rem.sv
// Iterative remainder unit: line number modulo set count.
`timescale 1ns / 1ps
module csm_set_rem
   import csm_pkg::*;
#(
   parameter int LINE_BITS = 26
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LINE_BITS-1:0] dividend,
   input  logic [CSR_W-1:0]     divisor,
   output logic                 done,
   output logic [CSR_W-1:0]     rem
);

   localparam int CYCLES   = (LINE_BITS + REM_STEPS - 1) / REM_STEPS;
   localparam int PAD_BITS = CYCLES * REM_STEPS;
   localparam int CNT_BITS = $clog2(CYCLES + 1);

   logic [PAD_BITS-1:0] shift_ff, shift_in;
   logic [CSR_W-1:0]    rem_ff, rem_in;
   logic [CSR_W-1:0]    div_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   // Restoring remainder, REM_STEPS dividend bits per cycle, MSB first.
   always_comb begin
      logic [CSR_W:0]      trial;
      logic [CSR_W-1:0]    r;
      logic [PAD_BITS-1:0] sh;
      r  = rem_ff;
      sh = shift_ff;
      for (int s = 0; s < REM_STEPS; s++) begin
         trial = {r, sh[PAD_BITS-1]};
         sh    = sh << 1;
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         r = trial[CSR_W-1:0];
      end
      rem_in   = r;
      shift_in = sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            shift_ff <= PAD_BITS'(dividend);
            rem_ff   <= '0;
            div_ff   <= divisor;
            cnt_ff   <= CNT_BITS'(CYCLES);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            shift_ff <= shift_in;
            rem_ff   <= rem_in;
            cnt_ff   <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: rtl/core/csm_way_store.sv
// Per-set tag, rank and valid memory with registered read and a clearing pass after reset.
`timescale 1ns / 1ps
module csm_way_store #(
   parameter int SETS      = 128,
   parameter int WAYS      = 4,
   parameter int LINE_BITS = 26,
   parameter int RANK_BITS = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   output logic                                 clearing,
   input  logic                                 rd_en,
   input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] rd_set,
   output logic [WAYS-1:0][LINE_BITS-1:0]       rd_tags,
   output logic [WAYS-1:0][RANK_BITS-1:0]       rd_ranks,
   output logic [WAYS-1:0]                      rd_valid,
   input  logic                                 wr_en,
   input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] wr_set,
   input  logic [WAYS-1:0][LINE_BITS-1:0]       wr_tags,
   input  logic [WAYS-1:0][RANK_BITS-1:0]       wr_ranks,
   input  logic [WAYS-1:0]                      wr_valid
);

   localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAG_W    = WAYS * LINE_BITS;
   localparam int RANK_W   = WAYS * RANK_BITS;
   localparam int ROW_W    = TAG_W + RANK_W + WAYS;

   logic [ROW_W-1:0]    mem [SETS];
   logic [ROW_W-1:0]    rd_row_ff;
   logic [SET_BITS-1:0] clr_idx_ff;
   logic                clearing_ff;

   // Walk every set once after reset, one row per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clearing_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == SET_BITS'(SETS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Ranks and tags of an invalid way are don't-care: valid masks them.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_set] <= {wr_valid, wr_ranks, wr_tags};
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_set];
      end
   end

   assign clearing = clearing_ff;
   assign rd_tags  = rd_row_ff[TAG_W-1:0];
   assign rd_ranks = rd_row_ff[TAG_W+RANK_W-1:TAG_W];
   assign rd_valid = rd_row_ff[ROW_W-1:TAG_W+RANK_W];

endmodule

FILE: rtl/core/csm_lru_logic.sv
// Hit detection, victim choice and LRU rank update for one set.
`timescale 1ns / 1ps
module csm_lru_logic #(
   parameter int WAYS      = 4,
   parameter int LINE_BITS = 26,
   parameter int RANK_BITS = 2
) (
   input  logic [LINE_BITS-1:0]           line,
   input  logic [WAYS-1:0][LINE_BITS-1:0] tags,
   input  logic [WAYS-1:0][RANK_BITS-1:0] ranks,
   input  logic [WAYS-1:0]                valid,
   output logic                           hit,
   output logic [WAYS-1:0][LINE_BITS-1:0] new_tags,
   output logic [WAYS-1:0][RANK_BITS-1:0] new_ranks,
   output logic [WAYS-1:0]                new_valid
);

   localparam int WAY_BITS = RANK_BITS;

   always_comb begin
      logic                 hit_found, free_found, lru_found;
      logic [WAY_BITS-1:0]  hit_way, free_way, lru_way, tgt;
      logic [RANK_BITS:0]   limit;
      hit_found  = 1'b0;
      free_found = 1'b0;
      lru_found  = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      lru_way    = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit_found && valid[w] && (tags[w] == line)) begin
            hit_found = 1'b1;
            hit_way   = WAY_BITS'(w);
         end
         if (!free_found && !valid[w]) begin
            free_found = 1'b1;
            free_way   = WAY_BITS'(w);
         end
         if (!lru_found && (ranks[w] == RANK_BITS'(WAYS - 1))) begin
            lru_found = 1'b1;
            lru_way   = WAY_BITS'(w);
         end
      end

      // The hit way on a hit, else the lowest free way, else the least recent way.
      if (hit_found) begin
         tgt = hit_way;
      end else if (free_found) begin
         tgt = free_way;
      end else if (lru_found) begin
         tgt = lru_way;
      end else begin
         tgt = '0;
      end

      // On a hit only the entries more recent than the hit one age.
      if (hit_found) begin
         limit = {1'b0, ranks[hit_way]};
      end else begin
         limit = (RANK_BITS + 1)'(WAYS);
      end

      for (int w = 0; w < WAYS; w++) begin
         if (WAY_BITS'(w) == tgt) begin
            new_ranks[w] = '0;
            new_valid[w] = 1'b1;
            new_tags[w]  = hit_found ? tags[w] : line;
         end else begin
            new_valid[w] = valid[w];
            new_tags[w]  = tags[w];
            if (valid[w] && ({1'b0, ranks[w]} < limit)) begin
               new_ranks[w] = ranks[w] + 1'b1;
            end else begin
               new_ranks[w] = ranks[w];
            end
         end
      end
      hit = hit_found;
   end

endmodule

FILE: rtl/core/csm_checker.sv
// Port-level checker for the LRU cache tag model, bound to the top level.
`timescale 1ns / 1ps
module csm_checker
   import csm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic              rsp_hit,
   input logic [MISS_W-1:0] rsp_miss_total
);

   logic [MISS_W-1:0] last_total_ff;

   // Track the total reported with the previous item.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
      end else if (rsp_valid) begin
         last_total_ff <= rsp_miss_total;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while an item is still at work");

   a_hit_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_miss_total == last_total_ff)
      else $error("miss total moved on a hit");

   a_miss_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
         (rsp_miss_total == last_total_ff + 1'b1) ||
         ((last_total_ff == '1) && (rsp_miss_total == '1)))
      else $error("miss total did not advance by one on a miss");

endmodule

bind set_assoc_lru_cache_model csm_checker u_csm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_miss_total (rsp_miss_total)
);
